[src/dlpm_pkg.sv]
package dlpm_pkg;

    localparam int STATE_W   = 8;
    localparam int SYM_W     = 7;
    localparam int NUM_SYMS  = 128;
    localparam int ENTRY_W   = 9;
    localparam int LEN_W     = 11;
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = 2;
    localparam int RES_CNT_W = 3;

    localparam logic [1:0] CMD_TRANS  = 2'd0;
    localparam logic [1:0] CMD_FINAL  = 2'd1;
    localparam logic [1:0] CMD_SYMBOL = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic [STATE_W-1:0] state_index;
        logic [SYM_W-1:0]   symbol;
        logic [STATE_W-1:0] next_state;
        logic               entry_valid;
        logic               is_final;
        logic               last_symbol;
    } t_in_beat;

    typedef struct packed {
        logic [LEN_W-1:0] accepted_length;
        logic [LEN_W-1:0] string_length;
        logic             stopped_early;
    } t_out_beat;

endpackage

[src/dlpm_ram.sv]
module dlpm_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 32768,
    parameter int AW    = 15
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/dlpm_fifo.sv]
module dlpm_fifo (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  dlpm_pkg::t_out_beat            i_push_data,
    input  logic                           i_pop,
    output logic                           o_valid,
    output dlpm_pkg::t_out_beat            o_data,
    output logic [dlpm_pkg::RES_CNT_W-1:0] o_count
);

    dlpm_pkg::t_out_beat                r_buf [dlpm_pkg::RES_DEPTH];
    logic [dlpm_pkg::RES_PTR_W-1:0]     r_wr_ptr;
    logic [dlpm_pkg::RES_PTR_W-1:0]     r_rd_ptr;
    logic [dlpm_pkg::RES_CNT_W-1:0]     r_count;
    logic [dlpm_pkg::RES_CNT_W-1:0]     n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + dlpm_pkg::RES_CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - dlpm_pkg::RES_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + dlpm_pkg::RES_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + dlpm_pkg::RES_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_buf[r_rd_ptr];
    assign o_count = r_count;

endmodule

[src/dfa_longest_prefix_matcher_unit.sv]
// A result passes the stage 1 and stage 2 registers, then the result FIFO.
// Throughput: one beat per cycle while input ready is high; the transition table
// read of one symbol forms the next symbol's read address in the following cycle.
// Reset: synchronous, active low; afterwards the table and final flags are swept
// to zero, all min(NUM_STATES, 256) * 128 table entries, with input ready held low.
module dfa_longest_prefix_matcher_unit #(
    parameter int NUM_STATES = 256,
    parameter int MAX_STRING = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [7:0]          i_cfg_wr_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dlpm_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dlpm_pkg::t_out_beat o_out_data
);

    localparam int EFF_STATES = (NUM_STATES < 256) ? NUM_STATES : 256;
    localparam int SW         = (EFF_STATES > 1) ? $clog2(EFF_STATES) : 1;
    localparam int TAW        = SW + dlpm_pkg::SYM_W;
    localparam int TDEPTH     = EFF_STATES * dlpm_pkg::NUM_SYMS;
    localparam int PW         = $clog2(MAX_STRING + 1);
    localparam int SWD        = dlpm_pkg::STATE_W;
    localparam int CW         = dlpm_pkg::RES_CNT_W;

    logic [SWD-1:0] r_start_state;
    logic           r_clr_busy;
    logic [TAW-1:0] r_clr_addr;

    logic [PW-1:0]  r_pos;
    logic [SWD-1:0] r_cur_state;
    logic           r_halted;
    logic [PW-1:0]  r_acc;

    logic           r_s1_v;
    logic           r_s1_first;
    logic           r_s1_cnt;
    logic           r_s1_sok;
    logic           r_s1_last;
    logic [PW-1:0]  r_s1_pos;

    logic           r_s2_v;
    logic           r_s2_first;
    logic           r_s2_hit;
    logic           r_s2_last;
    logic           r_s2_halt;
    logic [PW-1:0]  r_s2_pos;

    logic                       in_fire;
    logic                       sym_fire;
    logic                       first0;
    logic                       counted0;
    logic [PW-1:0]              pos_next0;
    logic [SWD-1:0]             cur_state;
    logic [SWD-1:0]             addr_state;
    logic                       state_ok0;
    logic                       wr_state_ok;

    logic                       tbl_we;
    logic [TAW-1:0]             tbl_waddr;
    logic [dlpm_pkg::ENTRY_W-1:0] tbl_wdata;
    logic [TAW-1:0]             tbl_raddr;
    logic [dlpm_pkg::ENTRY_W-1:0] tbl_rdata;

    logic                       flg_we;
    logic [SW-1:0]              flg_waddr;
    logic                       flg_wdata;
    logic                       flg_rdata;

    logic                       h_prev;
    logic                       walk1;
    logic                       ent_ok;
    logic                       s1_adv;
    logic                       h_new;
    logic                       nxt_ok;

    logic [PW-1:0]              acc_prev;
    logic [PW-1:0]              acc_new;
    logic                       res_push;
    dlpm_pkg::t_out_beat        res_data;
    logic [CW-1:0]              fifo_count;
    logic [CW-1:0]              pending;

    // stage 0: accept, issue table read
    assign in_fire     = i_in_valid && o_in_ready;
    assign sym_fire    = in_fire && (i_in_data.command == dlpm_pkg::CMD_SYMBOL);
    assign first0      = (r_pos == '0);
    assign counted0    = ({1'b0, r_pos} < (PW + 1)'(MAX_STRING));
    assign pos_next0   = counted0 ? r_pos + PW'(1) : r_pos;
    assign cur_state   = s1_adv ? tbl_rdata[SWD-1:0] : r_cur_state;
    assign addr_state  = first0 ? r_start_state : cur_state;
    assign state_ok0   = (int'(addr_state) < NUM_STATES);
    assign wr_state_ok = (int'(i_in_data.state_index) < NUM_STATES);
    assign tbl_raddr   = {addr_state[SW-1:0], i_in_data.symbol};

    always_comb begin
        tbl_we    = 1'b0;
        tbl_waddr = {i_in_data.state_index[SW-1:0], i_in_data.symbol};
        tbl_wdata = i_in_data.entry_valid ? {1'b1, i_in_data.next_state} : '0;
        flg_we    = 1'b0;
        flg_waddr = i_in_data.state_index[SW-1:0];
        flg_wdata = i_in_data.is_final;
        if (r_clr_busy) begin
            tbl_we    = 1'b1;
            tbl_waddr = r_clr_addr;
            tbl_wdata = '0;
            flg_we    = (r_clr_addr < TAW'(EFF_STATES));
            flg_waddr = r_clr_addr[SW-1:0];
            flg_wdata = 1'b0;
        end else if (in_fire && wr_state_ok) begin
            tbl_we = (i_in_data.command == dlpm_pkg::CMD_TRANS);
            flg_we = (i_in_data.command == dlpm_pkg::CMD_FINAL);
        end
    end

    dlpm_ram #(
        .WIDTH (dlpm_pkg::ENTRY_W),
        .DEPTH (TDEPTH),
        .AW    (TAW)
    ) u_tbl (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    // stage 1: resolve transition, issue final flag read
    assign h_prev = r_s1_first ? 1'b0 : r_halted;
    assign walk1  = r_s1_v && r_s1_cnt && !h_prev;
    assign ent_ok = r_s1_sok && tbl_rdata[SWD];
    assign s1_adv = walk1 && ent_ok;
    assign h_new  = (walk1 && !ent_ok) ? 1'b1 : h_prev;
    assign nxt_ok = (int'(tbl_rdata[SWD-1:0]) < NUM_STATES);

    dlpm_ram #(
        .WIDTH (1),
        .DEPTH (EFF_STATES),
        .AW    (SW)
    ) u_flg (
        .i_clk   (i_clk),
        .i_we    (flg_we),
        .i_waddr (flg_waddr),
        .i_wdata (flg_wdata),
        .i_raddr (tbl_rdata[SW-1:0]),
        .o_rdata (flg_rdata)
    );

    // stage 2: record accepted length, emit on last symbol
    assign acc_prev = r_s2_first ? '0 : r_acc;
    assign acc_new  = (r_s2_hit && flg_rdata) ? r_s2_pos : acc_prev;
    assign res_push = r_s2_v && r_s2_last;

    always_comb begin
        res_data.accepted_length = dlpm_pkg::LEN_W'(acc_new);
        res_data.string_length   = dlpm_pkg::LEN_W'(r_s2_pos);
        res_data.stopped_early   = r_s2_halt;
    end

    dlpm_fifo u_res (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_push),
        .i_push_data (res_data),
        .i_pop       (o_out_valid && i_out_ready),
        .o_valid     (o_out_valid),
        .o_data      (o_out_data),
        .o_count     (fifo_count)
    );

    assign pending    = fifo_count + CW'(r_s1_v && r_s1_last) + CW'(r_s2_v && r_s2_last);
    assign o_in_ready = !r_clr_busy && (pending < CW'(dlpm_pkg::RES_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_state <= '0;
            r_clr_busy    <= 1'b1;
            r_clr_addr    <= '0;
            r_pos         <= '0;
            r_cur_state   <= '0;
            r_halted      <= 1'b0;
            r_acc         <= '0;
            r_s1_v        <= 1'b0;
            r_s2_v        <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_start_state <= i_cfg_wr_data;
            end
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + TAW'(1);
                if (r_clr_addr == TAW'(TDEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (sym_fire) begin
                r_pos <= i_in_data.last_symbol ? '0 : pos_next0;
            end
            if (r_s1_v) begin
                r_halted <= h_new;
            end
            if (s1_adv) begin
                r_cur_state <= tbl_rdata[SWD-1:0];
            end
            if (r_s2_v) begin
                r_acc <= acc_new;
            end
            r_s1_v <= sym_fire;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_first <= first0;
        r_s1_cnt   <= counted0;
        r_s1_sok   <= state_ok0;
        r_s1_last  <= i_in_data.last_symbol;
        r_s1_pos   <= pos_next0;
        r_s2_first <= r_s1_first;
        r_s2_hit   <= s1_adv && nxt_ok;
        r_s2_last  <= r_s1_last;
        r_s2_halt  <= h_new;
        r_s2_pos   <= r_s1_pos;
    end

endmodule

[tb/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_STATES  = 256;
    localparam int MAX_STRING  = 1024;
    localparam int TABLE_DEPTH = NUM_STATES * dlpm_pkg::NUM_SYMS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 13;
    localparam int SETTLE      = 10;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cfg_wr_en;
    logic [7:0] i_cfg_wr_data;
    logic      i_in_valid;
    logic      o_in_ready;
    dlpm_pkg::t_in_beat  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    dlpm_pkg::t_out_beat o_out_data;

    dfa_longest_prefix_matcher_unit #(
        .NUM_STATES(NUM_STATES),
        .MAX_STRING(MAX_STRING)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data)
    );

    dlpm_pkg::t_in_beat  pending_beats[$];
    dlpm_pkg::t_out_beat expected_matches[$];

    bit              tbl_valid [TABLE_DEPTH];
    logic [7:0]      tbl_next [TABLE_DEPTH];
    bit              accepting [NUM_STATES];
    logic [7:0]      start_cfg = '0;
    logic [7:0]      walk_state = '0;
    logic [dlpm_pkg::LEN_W-1:0] walk_pos = '0;
    logic [dlpm_pkg::LEN_W-1:0] best_len = '0;
    bit              walk_halted = 1'b0;

    bit calm_phase = 1'b0;
    bit in_beat_taken = 1'b0;
    int cycle_count = 0;
    int beats_accepted = 0;
    int matches_checked = 0;
    int mismatch_count = 0;
    int start_settings = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic advance_matcher(input dlpm_pkg::t_in_beat b);
        dlpm_pkg::t_out_beat r;
        case (b.command)
            dlpm_pkg::CMD_TRANS: begin
                tbl_valid[{b.state_index, b.symbol}] = b.entry_valid;
                tbl_next[{b.state_index, b.symbol}] = b.entry_valid ? b.next_state : '0;
            end
            dlpm_pkg::CMD_FINAL: begin
                accepting[b.state_index] = b.is_final;
            end
            dlpm_pkg::CMD_SYMBOL: begin
                if (walk_pos < MAX_STRING) begin
                    if (walk_pos == 0)
                        walk_state = start_cfg;
                    walk_pos = walk_pos + 1'b1;
                    if (!walk_halted) begin
                        if (!tbl_valid[{walk_state, b.symbol}]) begin
                            walk_halted = 1'b1;
                        end else begin
                            walk_state = tbl_next[{walk_state, b.symbol}];
                            if (accepting[walk_state])
                                best_len = walk_pos;
                        end
                    end
                end
                if (b.last_symbol) begin
                    r.accepted_length = best_len;
                    r.string_length   = walk_pos;
                    r.stopped_early   = walk_halted;
                    expected_matches.push_back(r);
                    walk_state  = start_cfg;
                    walk_pos    = '0;
                    best_len    = '0;
                    walk_halted = 1'b0;
                end
            end
            default: ;
        endcase
    endtask

    function automatic dlpm_pkg::t_in_beat random_beat();
        dlpm_pkg::t_in_beat b;
        b.command     = 2'($urandom_range(3));
        b.state_index = 8'($urandom_range(255));
        b.symbol      = 7'($urandom_range(127));
        b.next_state  = 8'($urandom_range(255));
        b.entry_valid = 1'($urandom_range(1));
        b.is_final    = 1'($urandom_range(1));
        b.last_symbol = 1'($urandom_range(1));
        return b;
    endfunction

    task automatic queue_beat(input logic [1:0] cmd, input logic [7:0] st,
                              input logic [6:0] sym, input logic [7:0] nxt,
                              input logic ev, input logic fin, input logic last);
        dlpm_pkg::t_in_beat b;
        b.command     = cmd;
        b.state_index = st;
        b.symbol      = sym;
        b.next_state  = nxt;
        b.entry_valid = ev;
        b.is_final    = fin;
        b.last_symbol = last;
        pending_beats.push_back(b);
    endtask

    task automatic queue_symbol(input logic [6:0] sym, input logic last);
        dlpm_pkg::t_in_beat b;
        b = random_beat();
        b.command     = dlpm_pkg::CMD_SYMBOL;
        b.symbol      = sym;
        b.last_symbol = last;
        pending_beats.push_back(b);
    endtask

    task automatic queue_dfa_phase(input int n_beats, input int valid_pct, input int noise_pct);
        logic [6:0] alphabet [4];
        logic [7:0] pool [6];
        dlpm_pkg::t_in_beat b;
        int         queued;
        int         len;
        logic [6:0] sym;
        queued = 0;
        foreach (alphabet[i])
            alphabet[i] = 7'($urandom_range(127));
        pool[0] = start_cfg;
        for (int i = 1; i < 6; i++)
            pool[i] = 8'($urandom_range(255));
        foreach (pool[s]) begin
            foreach (alphabet[a]) begin
                b = random_beat();
                b.command     = dlpm_pkg::CMD_TRANS;
                b.state_index = pool[s];
                b.symbol      = alphabet[a];
                b.next_state  = pool[$urandom_range(5)];
                b.entry_valid = ($urandom_range(99) < valid_pct);
                pending_beats.push_back(b);
                queued++;
            end
            b = random_beat();
            b.command     = dlpm_pkg::CMD_FINAL;
            b.state_index = pool[s];
            pending_beats.push_back(b);
            queued++;
        end
        while (queued < n_beats) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(99) < noise_pct) begin
                    pending_beats.push_back(random_beat());
                    queued++;
                end
                sym = ($urandom_range(99) < 85) ? alphabet[$urandom_range(3)]
                                                : 7'($urandom_range(127));
                queue_symbol(sym, k == len - 1);
                queued++;
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || expected_matches.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_start_state(input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        start_cfg = value;
        start_settings++;
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_beat_taken) begin
            if (pending_beats.size() != 0 && (calm_phase || $urandom_range(99) >= IDLE_PCT)) begin
                i_in_valid <= 1'b1;
                i_in_data  <= pending_beats[0];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        in_beat_taken = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_ready <= calm_phase || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        dlpm_pkg::t_out_beat want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                advance_matcher(i_in_data);
                void'(pending_beats.pop_front());
                in_beat_taken = 1'b1;
                beats_accepted++;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_matches.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected match result: acc=%0d len=%0d stop=%0d",
                                 o_out_data.accepted_length, o_out_data.string_length,
                                 o_out_data.stopped_early);
                    mismatch_count++;
                end else begin
                    want = expected_matches.pop_front();
                    matches_checked++;
                    if (o_out_data.accepted_length !== want.accepted_length ||
                        o_out_data.string_length !== want.string_length ||
                        o_out_data.stopped_early !== want.stopped_early) begin
                        if (mismatch_count < 10) begin
                            $display("match result mismatch: expected acc=%0d len=%0d stop=%0d",
                                     want.accepted_length, want.string_length,
                                     want.stopped_early);
                            $display("    got acc=%0d len=%0d stop=%0d",
                                     o_out_data.accepted_length,
                                     o_out_data.string_length, o_out_data.stopped_early);
                        end
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin
        logic [6:0] loop_sym;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_out_ready   = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_beat(dlpm_pkg::CMD_SYMBOL, 8'h00, 7'h00, 8'h00, 1'b0, 1'b0, 1'b1);
        queue_beat(dlpm_pkg::CMD_TRANS,  8'h00, 7'h7F, 8'hFF, 1'b1, 1'b0, 1'b0);
        queue_beat(dlpm_pkg::CMD_FINAL,  8'hFF, 7'h00, 8'h00, 1'b0, 1'b1, 1'b1);
        queue_beat(dlpm_pkg::CMD_TRANS,  8'hFF, 7'h00, 8'h00, 1'b1, 1'b0, 1'b1);
        queue_beat(dlpm_pkg::CMD_FINAL,  8'h00, 7'h7F, 8'hFF, 1'b1, 1'b1, 1'b0);
        queue_symbol(7'h7F, 1'b0);
        queue_symbol(7'h00, 1'b0);
        queue_symbol(7'h7F, 1'b0);
        queue_symbol(7'h55, 1'b1);
        queue_beat(CMD_UNUSED, 8'hFF, 7'h7F, 8'hFF, 1'b1, 1'b1, 1'b1);
        queue_beat(dlpm_pkg::CMD_TRANS,  8'hFF, 7'h00, 8'hFF, 1'b0, 1'b1, 1'b0);
        queue_symbol(7'h7F, 1'b0);
        queue_symbol(7'h00, 1'b1);
        queue_symbol(7'h7F, 1'b0);
        queue_beat(dlpm_pkg::CMD_TRANS,  8'hFF, 7'h01, 8'h00, 1'b1, 1'b0, 1'b0);
        queue_symbol(7'h01, 1'b1);
        queue_beat(dlpm_pkg::CMD_FINAL,  8'h00, 7'h00, 8'h00, 1'b0, 1'b0, 1'b0);
        queue_symbol(7'h7F, 1'b0);
        queue_symbol(7'h01, 1'b1);
        queue_symbol(7'h7F, 1'b1);
        wait_drained();

        set_start_state(8'hFF);
        queue_dfa_phase(200, 90, 5);
        wait_drained();

        set_start_state(8'h00);
        calm_phase = 1'b1;
        queue_dfa_phase(200, 95, 0);
        wait_drained();
        calm_phase = 1'b0;

        set_start_state(8'($urandom_range(1, 254)));
        queue_dfa_phase(200, 70, 8);
        wait_drained();

        set_start_state(8'($urandom_range(1, 254)));
        loop_sym = 7'($urandom_range(127));
        queue_beat(dlpm_pkg::CMD_TRANS, start_cfg, loop_sym, start_cfg, 1'b1, 1'b0, 1'b0);
        queue_beat(dlpm_pkg::CMD_FINAL, start_cfg, loop_sym, start_cfg, 1'b0, 1'b1, 1'b0);
        for (int k = 0; k < MAX_STRING + 6; k++)
            queue_symbol(loop_sym, k == MAX_STRING + 5);
        queue_symbol(loop_sym, 1'b0);
        queue_symbol(7'($urandom_range(127)), 1'b1);
        wait_drained();

        set_start_state(8'($urandom_range(255)));
        queue_dfa_phase(200, 85, 15);
        wait_drained();

        set_start_state(8'($urandom_range(255)));
        queue_dfa_phase(200, 90, 5);
        wait_drained();

        $display("summary: %0d input beats, %0d match results checked, %0d start states",
                 beats_accepted, matches_checked, start_settings);
        $display("summary: includes strings past the length cap; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
